/* rtl/bitmap_priority_ready_queue_defines.svh */
// Assertion macros shared by the bitmap priority ready queue RTL.
`ifndef BITMAP_PRIORITY_READY_QUEUE_DEFINES_SVH
`define BITMAP_PRIORITY_READY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPRQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bprq_pkg.sv */
// Types, codes and defaults for the bitmap priority ready queue.
package bprq_pkg;

   localparam int LEVELS_DEF      = 32;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;

   localparam int CMD_W    = 2;
   localparam int TASK_W   = 8;
   localparam int LEVEL_W  = 5;
   localparam int STATUS_W = 2;
   localparam int READY_W  = 32;
   localparam int LIMIT_W  = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DISP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BOOST = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [TASK_W-1:0]  task_id;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] target_level;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   task_out;
      logic [LEVEL_W-1:0]  level_out;
      logic [READY_W-1:0]  ready_levels;
   } rsp_type;

endpackage

/* rtl/bprq_ffs.sv */
// Find-first-set over the ready bitmap: lowest set bit index.
module bprq_ffs #(
   parameter int WIDTH = bprq_pkg::LEVELS_DEF
) (
   input  logic [WIDTH-1:0]         bits,
   output logic [$clog2(WIDTH)-1:0] index,
   output logic                     found
);
   import bprq_pkg::*;

   localparam int IDX_BITS = $clog2(WIDTH);

   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            index = IDX_BITS'(i);
         end
      end
      found = |bits;
   end

endmodule

/* rtl/bitmap_priority_ready_queue.sv */
// Top level of the bitmap priority ready queue: per-level task FIFOs in memory.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  bprq_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  bprq_pkg::rsp_type
//   csr_     in         csr_valid / csr_ready  queue_limit (5 bits)
//
// Enqueue, dispatch, no-op and rejected commands pass S_HEAD and S_EXEC after the transfer;
// a boost between two different levels also passes S_PUSH. The result is registered.
// The steps are set by the single-read-port level metadata memory followed by the
// queue memory read, each with a registered read port.
// Per-level valid bits stand in for cleared metadata after reset.
// A stalled result holds the final step; no new command is taken until the queue is idle.
`include "bitmap_priority_ready_queue_defines.svh"

module bitmap_priority_ready_queue #(
   parameter int LEVELS      = bprq_pkg::LEVELS_DEF,
   parameter int QUEUE_DEPTH = bprq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = bprq_pkg::ID_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bprq_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bprq_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bprq_pkg::LIMIT_W-1:0]   csr_data
);
   import bprq_pkg::*;

   localparam int LVL_BITS    = $clog2(LEVELS);
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int PTR_W1      = PTR_BITS + 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int META_W      = PTR_BITS + CNT_BITS;
   localparam int STORE_DEPTH = LEVELS << PTR_BITS;
   localparam int SADDR_BITS  = LVL_BITS + PTR_BITS;

   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HEAD = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_BITS'(1);
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_BITS'(1);
   endfunction

   // control and command registers
   logic [1:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [LEVEL_W-1:0]  lv_ff, lv_in;
   logic [LEVEL_W-1:0]  tg_ff, tg_in;
   logic [LVL_BITS-1:0] a_addr_ff, a_addr_in;
   logic                any_ff, any_in;
   logic [PTR_BITS-1:0] head_a_ff, head_a_in;
   logic [CNT_BITS-1:0] cnt_a_ff, cnt_a_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [LEVELS-1:0]   bitmap_ff, bitmap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // memories
   logic [META_W-1:0]   meta_mem [LEVELS];
   logic [META_W-1:0]   meta_rd_ff;
   logic                meta_rd_vld_ff;
   logic [LEVELS-1:0]   meta_vld_ff;
   logic [ID_BITS-1:0]  store_mem [STORE_DEPTH];
   logic [ID_BITS-1:0]  store_rd_ff;

   logic [LVL_BITS-1:0]   meta_rd_addr;
   logic                  meta_we;
   logic [LVL_BITS-1:0]   meta_wr_addr;
   logic [PTR_BITS-1:0]   meta_wr_head;
   logic [CNT_BITS-1:0]   meta_wr_cnt;
   logic [SADDR_BITS-1:0] store_rd_addr;
   logic                  store_we;
   logic [SADDR_BITS-1:0] store_wr_addr;
   logic [ID_BITS-1:0]    store_wr_data;

   logic [PTR_BITS-1:0] rd_head;
   logic [CNT_BITS-1:0] rd_cnt;
   logic [LVL_BITS-1:0] ffs_idx;
   logic                ffs_found;
   logic [LVL_BITS-1:0] b_addr;
   logic                req_accept;
   logic                out_free;
   logic                lv_ok, tg_ok, full_a, full_b;
   logic [PTR_W1-1:0]   tail_sum;
   logic [PTR_BITS-1:0] tail;
   logic [PTR_BITS-1:0] push_head;
   logic                push_go;
   logic                rsp_load;
   logic [STATUS_W-1:0] res_status;
   logic [ID_BITS-1:0]  res_task;
   logic [LEVEL_W-1:0]  res_level;

   bprq_ffs #(
      .WIDTH (LEVELS)
   ) u_ffs (
      .bits  (bitmap_ff),
      .index (ffs_idx),
      .found (ffs_found)
   );

   assign req_stall  = reset || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign rd_head = meta_rd_vld_ff ? meta_rd_ff[META_W-1:CNT_BITS] : '0;
   assign rd_cnt  = meta_rd_vld_ff ? meta_rd_ff[CNT_BITS-1:0] : '0;
   assign b_addr  = LVL_BITS'(tg_ff);

   // capture command at transfer
   always_comb begin
      cmd_in    = req_data.cmd;
      id_in     = ID_BITS'(req_data.task_id);
      lv_in     = req_data.level;
      tg_in     = req_data.target_level;
      any_in    = ffs_found;
      a_addr_in = (req_data.cmd == CMD_DISP) ? ffs_idx : LVL_BITS'(req_data.level);
      head_a_in = rd_head;
      cnt_a_in  = rd_cnt;
      limit_in  = csr_data;
   end

   assign meta_rd_addr  = (state_ff == S_IDLE) ? a_addr_in : b_addr;
   assign store_rd_addr = {a_addr_ff, (state_ff == S_HEAD) ? rd_head : head_a_ff};

   assign lv_ok  = 32'(lv_ff) < LEVELS;
   assign tg_ok  = 32'(tg_ff) < LEVELS;
   assign full_a = (32'(cnt_a_ff) >= 32'(limit_ff)) || (32'(cnt_a_ff) >= QUEUE_DEPTH);
   assign full_b = (32'(rd_cnt) >= 32'(limit_ff)) || (32'(rd_cnt) >= QUEUE_DEPTH);

   assign tail_sum  = PTR_W1'(head_a_ff) + PTR_W1'(cnt_a_ff);
   assign tail      = (32'(tail_sum) >= QUEUE_DEPTH) ?
                      PTR_BITS'(tail_sum - PTR_W1'(QUEUE_DEPTH)) : PTR_BITS'(tail_sum);
   assign push_head = ptr_dec(rd_head);

   always_comb begin
      state_in      = state_ff;
      meta_we       = 1'b0;
      meta_wr_addr  = a_addr_ff;
      meta_wr_head  = head_a_ff;
      meta_wr_cnt   = cnt_a_ff;
      store_we      = 1'b0;
      store_wr_addr = {a_addr_ff, tail};
      store_wr_data = id_ff;
      bitmap_in     = bitmap_ff;
      push_go       = 1'b0;
      rsp_load      = 1'b0;
      res_status    = ST_OK;
      res_task      = '0;
      res_level     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (cmd_ff)
               CMD_ENQ: begin
                  if (!lv_ok || full_a) begin
                     res_status = ST_FULL;
                  end else begin
                     store_we             = 1'b1;
                     meta_we              = 1'b1;
                     meta_wr_cnt          = cnt_a_ff + CNT_BITS'(1);
                     bitmap_in[a_addr_ff] = 1'b1;
                  end
               end
               CMD_DISP: begin
                  if (!any_ff) begin
                     res_status = ST_EMPTY;
                  end else begin
                     res_task     = store_rd_ff;
                     res_level    = LEVEL_W'(a_addr_ff);
                     meta_we      = 1'b1;
                     meta_wr_head = ptr_inc(head_a_ff);
                     meta_wr_cnt  = cnt_a_ff - CNT_BITS'(1);
                     if (cnt_a_ff == CNT_BITS'(1)) begin
                        bitmap_in[a_addr_ff] = 1'b0;
                     end
                  end
               end
               CMD_BOOST: begin
                  if (!lv_ok || (cnt_a_ff == '0)) begin
                     res_status = ST_EMPTY;
                  end else if (!tg_ok || full_b) begin
                     res_status = ST_FULL;
                  end else begin
                     res_task  = store_rd_ff;
                     res_level = tg_ff;
                     if (lv_ff != tg_ff) begin
                        push_go      = 1'b1;
                        meta_we      = 1'b1;
                        meta_wr_head = ptr_inc(head_a_ff);
                        meta_wr_cnt  = cnt_a_ff - CNT_BITS'(1);
                        if (cnt_a_ff == CNT_BITS'(1)) begin
                           bitmap_in[a_addr_ff] = 1'b0;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
            if (push_go) begin
               state_in = S_PUSH;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               meta_we   = 1'b0;
               store_we  = 1'b0;
               bitmap_in = bitmap_ff;
            end
         end
         S_PUSH: begin
            meta_wr_addr  = b_addr;
            meta_wr_head  = push_head;
            meta_wr_cnt   = rd_cnt + CNT_BITS'(1);
            store_wr_addr = {b_addr, push_head};
            store_wr_data = store_rd_ff;
            res_task      = store_rd_ff;
            res_level     = tg_ff;
            if (out_free) begin
               meta_we           = 1'b1;
               store_we          = 1'b1;
               bitmap_in[b_addr] = 1'b1;
               rsp_load          = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in             = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in.status       = res_status;
      rsp_data_in.task_out     = TASK_W'(res_task);
      rsp_data_in.level_out    = res_level;
      rsp_data_in.ready_levels = READY_W'(bitmap_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         bitmap_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         meta_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         bitmap_ff    <= bitmap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= limit_in;
         end
         if (meta_we) begin
            meta_vld_ff[meta_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= cmd_in;
         id_ff     <= id_in;
         lv_ff     <= lv_in;
         tg_ff     <= tg_in;
         a_addr_ff <= a_addr_in;
         any_ff    <= any_in;
      end
      if (state_ff == S_HEAD) begin
         head_a_ff <= head_a_in;
         cnt_a_ff  <= cnt_a_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // level metadata memory: head pointer and entry count per level
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wr_addr] <= {meta_wr_head, meta_wr_cnt};
      end
      meta_rd_ff     <= meta_mem[meta_rd_addr];
      meta_rd_vld_ff <= meta_vld_ff[meta_rd_addr];
   end

   // task id memory: one ring of QUEUE_DEPTH slots per level
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wr_addr] <= store_wr_data;
      end
      store_rd_ff <= store_mem[store_rd_addr];
   end

   `BPRQ_ASSERT_IMPLIES(a_disp_from_ready, clock, reset, rsp_load && (state_ff == S_EXEC) && (cmd_ff == CMD_DISP) && any_ff, bitmap_ff[a_addr_ff], "dispatch from a level not marked ready")
   `BPRQ_ASSERT_IMPLIES(a_count_bound, clock, reset, meta_we, 32'(meta_wr_cnt) <= QUEUE_DEPTH, "level entry count above queue depth")
   `BPRQ_ASSERT_IMPLIES(a_push_after_pop, clock, reset, state_ff == S_PUSH, ($past(state_ff) == S_EXEC) || ($past(state_ff) == S_PUSH), "push step without a preceding pop")
   `BPRQ_ASSERT_NEXT(a_transfer_starts, clock, reset, req_accept, state_ff == S_HEAD, "transfer did not start metadata lookup")

endmodule
